/* rtl/minicomputer_subset_core_assert.svh */
// Assertion macros used by the checker file of the minicomputer subset core.
// Depends on nothing; the using scope must declare clk and arst_n.
`ifndef MINICOMPUTER_SUBSET_CORE_ASSERT_SVH
`define MINICOMPUTER_SUBSET_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("minicomputer subset core: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("minicomputer subset core: next-cycle check failed");

`endif

/* rtl/mcs_pkg.sv */
// Types and constants of the minicomputer subset core.
// Used by every module of the core and by its checker; depends on nothing.
package mcs_pkg;

	// Function codes of a request transaction.
	localparam logic [1:0] FN_LOAD = 2'd0;
	localparam logic [1:0] FN_EXEC = 2'd1;
	localparam logic [1:0] FN_READ = 2'd2;
	localparam logic [1:0] FN_REG  = 2'd3;

	// Status codes of a response transaction.
	localparam logic [2:0] ST_DONE    = 3'd0;
	localparam logic [2:0] ST_EXEC    = 3'd1;
	localparam logic [2:0] ST_HALT    = 3'd2;
	localparam logic [2:0] ST_BAD     = 3'd3;
	localparam logic [2:0] ST_STOPPED = 3'd4;

	// Opcodes in bits 15:12.
	localparam logic [3:0] OPC_MOV = 4'd1;
	localparam logic [3:0] OPC_CMP = 4'd2;
	localparam logic [3:0] OPC_ADD = 4'd6;
	localparam logic [3:0] OPC_SUB = 4'd14;
	// Opcodes in bits 15:6.
	localparam logic [9:0] OP6_BR  = 10'd4;
	localparam logic [9:0] OP6_BEQ = 10'd12;
	localparam logic [9:0] OP6_ASR = 10'd50;
	localparam logic [9:0] OP6_ASL = 10'd51;
	// Opcodes in bits 15:9.
	localparam logic [6:0] OP7_BNE = 7'd1;
	localparam logic [6:0] OP7_SOB = 7'd63;

	// Addressing modes.
	localparam logic [2:0] MD_REG    = 3'd0;
	localparam logic [2:0] MD_DEF    = 3'd1;
	localparam logic [2:0] MD_AINC   = 3'd2;
	localparam logic [2:0] MD_AINCD  = 3'd3;
	localparam logic [2:0] MD_ADEC   = 3'd4;
	localparam logic [2:0] MD_ADECD  = 3'd5;
	localparam logic [2:0] MD_IDX    = 3'd6;
	localparam logic [2:0] MD_IDXD   = 3'd7;

	localparam logic [2:0] PC_REG = 3'd7;

	// Statistics counter slots.
	localparam int CNT_EXEC   = 0;
	localparam int CNT_FETCH  = 1;
	localparam int CNT_READ   = 2;
	localparam int CNT_WRITE  = 3;
	localparam int CNT_BRANCH = 4;
	localparam int CNT_TAKEN  = 5;
	localparam int NUM_CNT    = 6;

	typedef struct packed {
		logic [1:0]  func;
		logic [14:0] word_index;
		logic [2:0]  reg_select;
		logic [15:0] load_data;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] program_counter;
		logic [3:0]  flags_nzvc;
		logic [15:0] read_data;
		logic [31:0] executed_count;
		logic [31:0] fetched_count;
		logic [31:0] reads_count;
		logic [31:0] writes_count;
		logic [31:0] branch_count;
		logic [31:0] taken_count;
	} rsp_t;

	// One access to the word memory.
	typedef struct packed {
		logic        rd_en;
		logic [14:0] rd_idx;
		logic        wr_en;
		logic [14:0] wr_idx;
		logic [15:0] wr_data;
	} mem_req_t;

	// Result of the arithmetic unit.
	typedef struct packed {
		logic [15:0] result;
		logic [3:0]  flags;
		logic        store;
	} alu_out_t;

endpackage

/* rtl/mcs_mem.sv */
// Word memory of the minicomputer subset core, with a clearing pass after reset.
// Depends on mcs_pkg.
module mcs_mem import mcs_pkg::*; #(
	parameter int MEM_WORDS = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  mem_req_t    mreq,
	output logic [15:0] rdata,
	output logic        busy
);

	localparam int AW = $clog2(MEM_WORDS);
	localparam logic [15:0] MEM_LIMIT = 16'(MEM_WORDS);

	logic [15:0]   mem [MEM_WORDS];
	logic [AW-1:0] clr_idx_q;
	logic          clr_q;
	logic [15:0]   raw_q;
	logic          oor_q;
	logic          wr_ok;
	logic          rd_ok;

	assign wr_ok = {1'b0, mreq.wr_idx} < MEM_LIMIT;
	assign rd_ok = {1'b0, mreq.rd_idx} < MEM_LIMIT;

	// The clearing pass walks every word once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			if (clr_idx_q == AW'(MEM_WORDS - 1)) begin
				clr_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	// Single write port and a registered read port.
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_idx_q] <= '0;
		end else if (mreq.wr_en && wr_ok) begin
			mem[mreq.wr_idx[AW-1:0]] <= mreq.wr_data;
		end
		if (mreq.rd_en) begin
			raw_q <= mem[mreq.rd_idx[AW-1:0]];
			oor_q <= !rd_ok;
		end
	end

	// Words beyond the memory read as zero.
	assign rdata = oor_q ? 16'h0000 : raw_q;
	assign busy  = clr_q;

endmodule

/* rtl/mcs_alu.sv */
// Arithmetic unit of the minicomputer subset core: MOV, CMP, ADD, SUB, ASL, ASR.
// Depends on mcs_pkg.
module mcs_alu import mcs_pkg::*; (
	input  logic [15:0] ir,
	input  logic [15:0] src,
	input  logic [15:0] dst,
	input  logic [3:0]  flags_in,
	output alu_out_t    res
);

	logic [16:0] sum;
	logic [15:0] r;
	logic        v;
	logic        c;

	// Result, overflow and carry for the decoded operation.
	always_comb begin
		sum       = {1'b0, src} + {1'b0, dst};
		r         = src;
		v         = 1'b0;
		c         = flags_in[0];
		res.store = 1'b1;
		case (ir[15:12])
			OPC_MOV: begin
				r = src;
			end
			OPC_CMP: begin
				r         = src - dst;
				v         = (src[15] ^ dst[15]) && !(dst[15] ^ r[15]);
				c         = src < dst;
				res.store = 1'b0;
			end
			OPC_ADD: begin
				r = sum[15:0];
				v = !(src[15] ^ dst[15]) && (src[15] ^ r[15]);
				c = sum[16];
			end
			OPC_SUB: begin
				r = dst - src;
				v = (src[15] ^ dst[15]) && !(src[15] ^ r[15]);
				c = dst < src;
			end
			default: begin
				if (ir[15:6] == OP6_ASL) begin
					r = {dst[14:0], 1'b0};
					c = dst[15];
				end else begin
					r = {dst[15], dst[15:1]};
					c = dst[0];
				end
				v = r[15] ^ c;
			end
		endcase
		res.result = r;
		res.flags  = {r[15], r == 16'h0000, v, c};
	end

endmodule

/* rtl/minicomputer_subset_core.sv */
// Minicomputer subset core: instruction sequencer, register file and counters.
// Depends on mcs_pkg, mcs_mem and mcs_alu.
//
// Use: a request transaction (req_valid/req_stall, payload req) loads a memory
// word, executes one instruction, reads a memory word or reads a register.
// Each request gives exactly one response transaction (rsp_valid/rsp_stall,
// payload rsp) with status, PC, flags, read data and statistics counters.
// One request is worked on at a time; req_stall is low only while idle.
// Load and register read go straight to the response step, memory read
// passes a read step first, and execute steps through decode, operand,
// index, indirect, value and execute states or a branch state as needed.
// Every fetch, index word, pointer, operand read and write-back goes
// through the single memory port in its own step.
// The response sits in an output register; the next request may be taken
// while it waits, but a finished request waits in its last step while the
// receiver stalls. After reset the memory is cleared word by word,
// and no request is accepted while it is cleared.
module minicomputer_subset_core import mcs_pkg::*; #(
	parameter int MEM_WORDS = 32768
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_OP   = 4'd2;
	localparam logic [3:0] S_IDX  = 4'd3;
	localparam logic [3:0] S_IND  = 4'd4;
	localparam logic [3:0] S_VAL  = 4'd5;
	localparam logic [3:0] S_EXE  = 4'd6;
	localparam logic [3:0] S_BRX  = 4'd7;
	localparam logic [3:0] S_RDW  = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0]  state_q;
	logic [15:0] rf_q [8];
	logic [3:0]  flags_q;
	logic        stopped_q;
	logic [31:0] cnt_q [NUM_CNT];
	logic        rsp_valid_q;
	rsp_t        rsp_q;
	logic [15:0] ir_q;
	logic        opsel_q;
	logic [15:0] sval_q;
	logic [15:0] dval_q;
	logic [15:0] ea_q;
	logic [2:0]  status_q;
	logic [15:0] rdata_q;

	mem_req_t    mreq;
	logic [15:0] mem_rdata;
	logic        mem_busy;
	alu_out_t    alu;
	logic        acc;
	logic        slot_free;
	logic [2:0]  md;
	logic [2:0]  rn;
	logic [2:0]  rf_idx;
	logic [15:0] rval;
	logic [15:0] rval_p2;
	logic [15:0] rval_m2;
	logic [15:0] pc_p2;
	logic [15:0] idx_ea;
	logic [15:0] disp;
	logic [15:0] sob_nv;
	logic [15:0] sob_pc;
	logic        take;
	logic        is_sob;
	logic        two_op;
	logic        one_op;
	logic        br_op;
	logic [1:0]  inc [NUM_CNT];

	mcs_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.mreq   (mreq),
		.rdata  (mem_rdata),
		.busy   (mem_busy)
	);

	mcs_alu u_alu (
		.ir       (ir_q),
		.src      (sval_q),
		.dst      (dval_q),
		.flags_in (flags_q),
		.res      (alu)
	);

	assign req_stall = (state_q != S_IDLE) || mem_busy;
	assign acc       = req_valid && !req_stall;
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Operand fields and the register file read port; the PC is also read directly.
	assign md      = opsel_q ? ir_q[5:3] : ir_q[11:9];
	assign rn      = opsel_q ? ir_q[2:0] : ir_q[8:6];
	assign rf_idx  = (state_q == S_IDLE) ? req.reg_select : rn;
	assign rval    = rf_q[rf_idx];
	assign rval_p2 = rval + 16'd2;
	assign rval_m2 = rval - 16'd2;
	assign pc_p2   = rf_q[PC_REG] + 16'd2;
	assign idx_ea  = rval + mem_rdata;

	// Branch arithmetic.
	assign is_sob = ir_q[15:9] == OP7_SOB;
	assign disp   = {{7{ir_q[7]}}, ir_q[7:0], 1'b0};
	assign sob_nv = rval - 16'd1;
	always_comb begin
		if (is_sob) begin
			take = sob_nv != 16'h0000;
		end else if (ir_q[15:6] == OP6_BR) begin
			take = 1'b1;
		end else if (ir_q[15:6] == OP6_BEQ) begin
			take = flags_q[2];
		end else begin
			take = !flags_q[2];
		end
		sob_pc = ((rn == PC_REG) ? sob_nv : rf_q[PC_REG])
			- (take ? {9'b0, ir_q[5:0], 1'b0} : 16'h0000);
	end

	// Instruction classes of the fetched word.
	assign two_op = (mem_rdata[15:12] == OPC_MOV) || (mem_rdata[15:12] == OPC_CMP)
		|| (mem_rdata[15:12] == OPC_ADD) || (mem_rdata[15:12] == OPC_SUB);
	assign one_op = (mem_rdata[15:6] == OP6_ASR) || (mem_rdata[15:6] == OP6_ASL);
	assign br_op  = (mem_rdata[15:6] == OP6_BR) || (mem_rdata[15:6] == OP6_BEQ)
		|| (mem_rdata[15:9] == OP7_SOB) || (mem_rdata[15:9] == OP7_BNE);

	// Memory accesses and counter increments of the current step.
	always_comb begin
		mreq = '0;
		for (int i = 0; i < NUM_CNT; i++) begin
			inc[i] = 2'd0;
		end
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (req.func)
						FN_LOAD: begin
							mreq.wr_en   = 1'b1;
							mreq.wr_idx  = req.word_index;
							mreq.wr_data = req.load_data;
						end
						FN_EXEC: begin
							if (!stopped_q) begin
								mreq.rd_en       = 1'b1;
								mreq.rd_idx      = rf_q[PC_REG][15:1];
								inc[CNT_EXEC]    = 2'd1;
								inc[CNT_FETCH]   = 2'd1;
							end
						end
						FN_READ: begin
							mreq.rd_en  = 1'b1;
							mreq.rd_idx = req.word_index;
						end
						default: begin
						end
					endcase
				end
			end
			S_OP: begin
				case (md) inside
					MD_REG: begin
					end
					MD_DEF, MD_AINCD: begin
						mreq.rd_en    = 1'b1;
						mreq.rd_idx   = rval[15:1];
						inc[CNT_READ] = 2'd1;
					end
					MD_AINC: begin
						mreq.rd_en     = 1'b1;
						mreq.rd_idx    = rval[15:1];
						inc[CNT_FETCH] = (rn == PC_REG) ? 2'd1 : 2'd0;
					end
					MD_ADEC, MD_ADECD: begin
						mreq.rd_en    = 1'b1;
						mreq.rd_idx   = rval_m2[15:1];
						inc[CNT_READ] = 2'd1;
					end
					default: begin
						mreq.rd_en     = 1'b1;
						mreq.rd_idx    = rf_q[PC_REG][15:1];
						inc[CNT_FETCH] = 2'd1;
						inc[CNT_READ]  = 2'd3;
					end
				endcase
			end
			S_IDX: begin
				mreq.rd_en  = 1'b1;
				mreq.rd_idx = idx_ea[15:1];
			end
			S_IND: begin
				mreq.rd_en  = 1'b1;
				mreq.rd_idx = mem_rdata[15:1];
			end
			S_EXE: begin
				if (alu.store && (ir_q[5:3] != MD_REG)) begin
					mreq.wr_en     = 1'b1;
					mreq.wr_idx    = ea_q[15:1];
					mreq.wr_data   = alu.result;
					inc[CNT_WRITE] = 2'd1;
				end
			end
			S_BRX: begin
				inc[CNT_BRANCH] = 2'd1;
				inc[CNT_TAKEN]  = take ? 2'd1 : 2'd0;
			end
			default: begin
			end
		endcase
	end

	// Saturating statistics counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CNT; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < NUM_CNT; i++) begin
				if (({1'b0, cnt_q[i]} + {31'b0, inc[i]}) > 33'h0FFFFFFFF) begin
					cnt_q[i] <= 32'hFFFFFFFF;
				end else begin
					cnt_q[i] <= cnt_q[i] + {30'b0, inc[i]};
				end
			end
		end
	end

	// Sequencer, register file, flags and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stopped_q   <= 1'b0;
			flags_q     <= '0;
			opsel_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				rf_q[i] <= '0;
			end
		end else begin
			// A new response enters the output register, or a stalled one stays.
			rsp_valid_q <= ((state_q == S_DONE) && slot_free) || (rsp_valid_q && rsp_stall);
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (req.func)
							FN_EXEC: begin
								if (stopped_q) begin
									state_q <= S_DONE;
								end else begin
									rf_q[PC_REG] <= pc_p2;
									state_q      <= S_DEC;
								end
							end
							FN_READ: state_q <= S_RDW;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_DEC: begin
					opsel_q <= one_op;
					if (mem_rdata == 16'h0000) begin
						stopped_q <= 1'b1;
						state_q   <= S_DONE;
					end else if (two_op || one_op) begin
						state_q <= S_OP;
					end else if (br_op) begin
						state_q <= S_BRX;
					end else begin
						stopped_q <= 1'b1;
						state_q   <= S_DONE;
					end
				end
				S_OP: begin
					case (md)
						MD_REG: begin
							opsel_q <= 1'b1;
							state_q <= opsel_q ? S_EXE : S_OP;
						end
						MD_DEF: state_q <= S_VAL;
						MD_AINC: begin
							rf_q[rn] <= rval_p2;
							state_q  <= S_VAL;
						end
						MD_AINCD: begin
							rf_q[rn] <= rval_p2;
							state_q  <= S_IND;
						end
						MD_ADEC: begin
							rf_q[rn] <= rval_m2;
							state_q  <= S_VAL;
						end
						MD_ADECD: begin
							rf_q[rn] <= rval_m2;
							state_q  <= S_IND;
						end
						default: begin
							rf_q[PC_REG] <= pc_p2;
							state_q      <= S_IDX;
						end
					endcase
				end
				S_IDX: state_q <= (md == MD_IDXD) ? S_IND : S_VAL;
				S_IND: state_q <= S_VAL;
				S_VAL: begin
					opsel_q <= 1'b1;
					state_q <= opsel_q ? S_EXE : S_OP;
				end
				S_EXE: begin
					flags_q <= (ir_q[15:12] == OPC_MOV)
						? {alu.flags[3:2], 1'b0, flags_q[0]} : alu.flags;
					if (alu.store && (ir_q[5:3] == MD_REG)) begin
						rf_q[ir_q[2:0]] <= alu.result;
					end
					state_q <= S_DONE;
				end
				S_BRX: begin
					if (is_sob) begin
						if (rn != PC_REG) begin
							rf_q[rn] <= sob_nv;
						end
						rf_q[PC_REG] <= sob_pc;
					end else if (take) begin
						rf_q[PC_REG] <= rf_q[PC_REG] + disp;
					end
					state_q <= S_DONE;
				end
				S_RDW: state_q <= S_DONE;
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Instruction, operand, status and response payload registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				rdata_q  <= (req.func == FN_REG) ? rval : 16'h0000;
				status_q <= ((req.func == FN_EXEC) && stopped_q) ? ST_STOPPED : ST_DONE;
			end
			S_DEC: begin
				ir_q <= mem_rdata;
				if (mem_rdata == 16'h0000) begin
					status_q <= ST_HALT;
				end else if (two_op || one_op || br_op) begin
					status_q <= ST_EXEC;
				end else begin
					status_q <= ST_BAD;
				end
			end
			S_OP: begin
				case (md) inside
					MD_REG: begin
						if (opsel_q) begin
							dval_q <= rval;
						end else begin
							sval_q <= rval;
						end
					end
					MD_DEF, MD_AINC: ea_q <= rval;
					MD_ADEC: ea_q <= rval_m2;
					default: begin
					end
				endcase
			end
			S_IDX: ea_q <= idx_ea;
			S_IND: ea_q <= mem_rdata;
			S_VAL: begin
				if (opsel_q) begin
					dval_q <= mem_rdata;
				end else begin
					sval_q <= mem_rdata;
				end
			end
			S_RDW: rdata_q <= mem_rdata;
			S_DONE: begin
				if (slot_free) begin
					rsp_q.status          <= status_q;
					rsp_q.program_counter <= rf_q[PC_REG];
					rsp_q.flags_nzvc      <= flags_q;
					rsp_q.read_data       <= rdata_q;
					rsp_q.executed_count  <= cnt_q[CNT_EXEC];
					rsp_q.fetched_count   <= cnt_q[CNT_FETCH];
					rsp_q.reads_count     <= cnt_q[CNT_READ];
					rsp_q.writes_count    <= cnt_q[CNT_WRITE];
					rsp_q.branch_count    <= cnt_q[CNT_BRANCH];
					rsp_q.taken_count     <= cnt_q[CNT_TAKEN];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/mcs_checker.sv */
// Port-level checker of the minicomputer subset core, bound to the top level.
// Depends on mcs_pkg and minicomputer_subset_core_assert.svh.
`include "minicomputer_subset_core_assert.svh"

module mcs_checker import mcs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// A stalled response transaction holds its payload.
	`MCS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// The core works on one request at a time.
	`MCS_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall)

	// Status codes stay within the defined set.
	`MCS_ASSERT_NOW(a_status_range, rsp_valid, rsp.status <= ST_STOPPED)

	// Only transactions with status done (load, memory read, register read) may carry read data.
	`MCS_ASSERT_NOW(a_rdata_zero, rsp_valid && (rsp.status != ST_DONE),
		rsp.read_data == 16'h0000)

endmodule

bind minicomputer_subset_core mcs_checker u_mcs_checker (.*);
